[design/drdtm_pkg.sv]
// ---------------------------------------------------------------------------
// Display reply deframer package
// Shared constants and the command record passed from the deframing front
// end to the pair matching back end.
// ---------------------------------------------------------------------------
package drdtm_pkg;

  localparam int BufLenDefault   = 32;
  localparam int TableLenDefault = 16;
  localparam int QueueDepth      = 2;

  localparam logic [7:0] TouchCode = 8'h65;
  localparam logic [7:0] TermByte  = 8'hFF;

  localparam logic OpRxByte   = 1'b0;
  localparam logic OpRegister = 1'b1;

  localparam logic [1:0] KindRelease = 2'd0;
  localparam logic [1:0] KindPress   = 2'd1;
  localparam logic [1:0] KindOther   = 2'd2;

  // head[0] is the code byte; for a registration head[1] and head[2]
  // carry page and object, the same places as in a touch frame.
  typedef struct packed {
    logic            is_reg;
    logic [4:0]      msg_len;
    logic            is_touch;
    logic [3:0][7:0] head;
  } cmd_t;

endpackage

[design/drdtm_if.sv]
// ---------------------------------------------------------------------------
// Display reply deframer channels
// Valid/ready interfaces for the input items and the result items.
// ---------------------------------------------------------------------------
interface drdtm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] reg_page;
  logic [7:0] reg_object;

  modport source (output valid, output op, output rx_byte, output reg_page,
                  output reg_object, input ready);
  modport sink   (input valid, input op, input rx_byte, input reg_page,
                  input reg_object, output ready);
endinterface

interface drdtm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] msg_len;
  logic [7:0] code_byte;
  logic       is_touch;
  logic [7:0] touch_page;
  logic [7:0] touch_object;
  logic [1:0] touch_kind;
  logic       hit;
  logic [3:0] slot;

  modport source (output valid, output msg_len, output code_byte, output is_touch,
                  output touch_page, output touch_object, output touch_kind,
                  output hit, output slot, input ready);
  modport sink   (input valid, input msg_len, input code_byte, input is_touch,
                  input touch_page, input touch_object, input touch_kind,
                  input hit, input slot, output ready);
endinterface

[design/drdtm_front.sv]
// ---------------------------------------------------------------------------
// Display reply deframer front end
// Tracks write position and terminator run, keeps the first four frame
// bytes, and emits a command at each frame end or registration.
// ---------------------------------------------------------------------------
module drdtm_front #(
  parameter int BUF_LEN = drdtm_pkg::BufLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  drdtm_in_if.sink          in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output drdtm_pkg::cmd_t   cmd_o
);

  localparam int WpW = ($clog2(BUF_LEN + 1) > 5) ? $clog2(BUF_LEN + 1) : 5;
  localparam logic [WpW-1:0] WpClamp = WpW'(BUF_LEN - 3);
  localparam logic [WpW-1:0] WpMax   = WpW'(BUF_LEN - 1);

  logic [WpW-1:0]  wp_q, wp_d, wp_inc, len;
  logic [1:0]      tc_q, tc_d;
  logic [3:0][7:0] head_q, head_d;
  logic            accept, byte_acc, is_ff, done;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign byte_acc   = accept && (in_i.op == drdtm_pkg::OpRxByte);
  assign wp_inc     = wp_q + WpW'(1);
  assign len        = wp_inc - WpW'(3);
  assign is_ff      = (in_i.rx_byte == drdtm_pkg::TermByte);
  assign done       = is_ff && (tc_q == 2'd2);

  always_comb begin
    head_d = head_q;
    if (wp_q < WpW'(4)) begin
      head_d[wp_q[1:0]] = in_i.rx_byte;
    end
  end

  always_comb begin
    wp_d = wp_q;
    tc_d = tc_q;
    if (byte_acc) begin
      if (done) begin
        wp_d = '0;
        tc_d = '0;
      end else if (is_ff) begin
        wp_d = wp_inc;
        tc_d = tc_q + 2'd1;
      end else begin
        // hold the last kept byte slot once the buffer is full
        tc_d = '0;
        wp_d = (wp_inc > WpClamp) ? WpClamp : wp_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      tc_q   <= '0;
      head_q <= '0;
    end else begin
      wp_q <= wp_d;
      tc_q <= tc_d;
      if (byte_acc) begin
        head_q <= head_d;
      end
    end
  end

  assign cmd_valid_o = accept && ((in_i.op == drdtm_pkg::OpRegister) || done);

  always_comb begin
    cmd_o          = '0;
    cmd_o.is_reg   = (in_i.op == drdtm_pkg::OpRegister);
    if (in_i.op == drdtm_pkg::OpRegister) begin
      cmd_o.head[1] = in_i.reg_page;
      cmd_o.head[2] = in_i.reg_object;
    end else begin
      cmd_o.msg_len  = len[4:0];
      cmd_o.is_touch = (len == WpW'(4)) && (head_d[0] == drdtm_pkg::TouchCode);
      cmd_o.head     = head_d;
    end
  end

`ifndef SYNTH
  a_tc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q != 2'd3)
    else $error("terminator run reached three without ending the frame");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= WpMax)
    else $error("write position beyond buffer");
`endif

endmodule

[design/drdtm_queue.sv]
// ---------------------------------------------------------------------------
// Display reply deframer command queue
// Short FIFO that decouples the deframing front end from the matcher.
// ---------------------------------------------------------------------------
module drdtm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  drdtm_pkg::cmd_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output drdtm_pkg::cmd_t pop_data_o
);

  localparam int Depth = drdtm_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  drdtm_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[design/drdtm_back.sv]
// ---------------------------------------------------------------------------
// Display reply deframer matcher back end
// Holds the page/object pair ring, inserts new pairs, looks up touch
// frames and registers the result item.
// ---------------------------------------------------------------------------
module drdtm_back #(
  parameter int TABLE_LEN = drdtm_pkg::TableLenDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  drdtm_pkg::cmd_t cmd_i,
  drdtm_out_if.source     out_o
);

  localparam int IdxW = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StEval = 1'b1;

  typedef struct packed {
    logic [4:0] msg_len;
    logic [7:0] code_byte;
    logic       is_touch;
    logic [7:0] touch_page;
    logic [7:0] touch_object;
    logic [1:0] touch_kind;
    logic       hit;
    logic [3:0] slot;
  } res_t;

  logic                 state_q, state_d;
  drdtm_pkg::cmd_t      cmd_q;
  logic [15:0]          pair_q [TABLE_LEN];
  logic [TABLE_LEN-1:0] valid_q, match_q, match_d;
  logic [IdxW-1:0]      ins_q, first_idx;
  logic [15:0]          key_in;
  logic                 any_match, out_free, write_en, load_out, out_valid_q;
  res_t                 res_q, res_d;

  assign cmd_ready_o = (state_q == StIdle);
  assign key_in      = {cmd_i.head[1], cmd_i.head[2]};

  // compare stage: every slot against the incoming key
  always_comb begin
    for (int i = 0; i < TABLE_LEN; i++) begin
      match_d[i] = valid_q[i] && (pair_q[i] == key_in);
    end
  end

  // select stage: lowest matching slot
  always_comb begin
    first_idx = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end

  assign any_match = |match_q;
  assign out_free  = !out_valid_q || out_o.ready;
  assign write_en  = (state_q == StEval) && cmd_q.is_reg && !any_match;
  assign load_out  = (state_q == StEval) && !cmd_q.is_reg && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (cmd_q.is_reg || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res_d           = '0;
    res_d.msg_len   = cmd_q.msg_len;
    res_d.code_byte = cmd_q.head[0];
    res_d.is_touch  = cmd_q.is_touch;
    if (cmd_q.is_touch) begin
      res_d.touch_page   = cmd_q.head[1];
      res_d.touch_object = cmd_q.head[2];
      if (cmd_q.head[3] == 8'd0) begin
        res_d.touch_kind = drdtm_pkg::KindRelease;
      end else if (cmd_q.head[3] == 8'd1) begin
        res_d.touch_kind = drdtm_pkg::KindPress;
      end else begin
        res_d.touch_kind = drdtm_pkg::KindOther;
      end
      res_d.hit  = any_match;
      res_d.slot = any_match ? 4'(first_idx) : 4'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      cmd_q   <= cmd_i;
      match_q <= match_d;
    end
    if (write_en) begin
      pair_q[ins_q] <= {cmd_q.head[1], cmd_q.head[2]};
    end
    if (load_out) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      ins_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (write_en) begin
        valid_q[ins_q] <= 1'b1;
        ins_q <= (ins_q == IdxW'(TABLE_LEN - 1)) ? '0 : ins_q + IdxW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.msg_len      = res_q.msg_len;
  assign out_o.code_byte    = res_q.code_byte;
  assign out_o.is_touch     = res_q.is_touch;
  assign out_o.touch_page   = res_q.touch_page;
  assign out_o.touch_object = res_q.touch_object;
  assign out_o.touch_kind   = res_q.touch_kind;
  assign out_o.hit          = res_q.hit;
  assign out_o.slot         = res_q.slot;

`ifndef SYNTH
  a_plain_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.is_touch |-> !res_q.hit && (res_q.slot == 4'd0))
    else $error("non-touch result carries a match");

  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_en |=> valid_q[$past(ins_q)])
    else $error("inserted slot not marked valid");

  a_reg_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) && cmd_q.is_reg |=> (state_q == StIdle))
    else $error("registration did not finish in one evaluation cycle");
`endif

endmodule

[design/display_reply_deframer_touch_matcher_core.sv]
// ---------------------------------------------------------------------------
// Display reply deframer and touch matcher
// Top level: front end, command queue and matcher back end.
// ---------------------------------------------------------------------------
// Received bytes are gathered into frames ended by three 0xFF bytes; each
// frame end yields one result with the length and first byte, and a
// four-byte frame opening with 0x65 is decoded as a touch event whose
// page/object pair is looked up in a ring of registered pairs. The input
// accepts one byte per cycle while the two-entry command queue has room.
// Frame ends and registrations each pass through the matcher in order (a
// compare of all TABLE_LEN slots, then lowest-slot selection and table
// update), and it takes no new one until it is done with the last; a
// waiting result in the output register stalls only the matcher, and the
// byte path only once the queue fills.
// Registrations produce no result.
module display_reply_deframer_touch_matcher_core #(
  parameter int BUF_LEN   = drdtm_pkg::BufLenDefault,
  parameter int TABLE_LEN = drdtm_pkg::TableLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drdtm_in_if.sink    in_i,
  drdtm_out_if.source out_o
);

  logic            f_valid, f_ready, b_valid, b_ready;
  drdtm_pkg::cmd_t f_cmd, b_cmd;

  drdtm_front #(
    .BUF_LEN (BUF_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  drdtm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  drdtm_back #(
    .TABLE_LEN (TABLE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_o       (out_o)
  );

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// Display reply deframer and touch matcher testbench
// Sends received bytes and pair registrations over the input channel and
// predicts each frame report in step with the accepted items. A monitor
// takes the reports off the output channel and compares them field by field
// in order. The run covers idle and stall phases, a long output hold-off and
// pauses that drain the block.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BufLen   = drdtm_pkg::BufLenDefault;
  localparam int TableLen = drdtm_pkg::TableLenDefault;
  localparam int PoolSize = 24;

  typedef struct {
    logic       op;
    logic [7:0] rx_byte;
    logic [7:0] reg_page;
    logic [7:0] reg_object;
  } link_item_t;

  typedef struct {
    logic [4:0] msg_len;
    logic [7:0] code_byte;
    logic       is_touch;
    logic [7:0] touch_page;
    logic [7:0] touch_object;
    logic [1:0] touch_kind;
    logic       hit;
    logic [3:0] slot;
  } frame_report_t;

  logic clk_i;
  logic rst_ni;

  drdtm_in_if  in_ch ();
  drdtm_out_if out_ch ();

  display_reply_deframer_touch_matcher_core u_top (
    .clk_i,
    .rst_ni,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  link_item_t    link_items[$];
  frame_report_t reports_due[$];
  link_item_t    on_wire;
  logic [15:0]   pair_pool[PoolSize];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int errors        = 0;
  int pushed        = 0;

  // Predicted deframer and pair table state
  int          wr_pos  = 0;
  int          ff_run  = 0;
  int          ins_pos = 0;
  logic [7:0]  head[4] = '{default: 8'h00};
  logic [15:0] pair_key[TableLen];
  logic        pair_vld[TableLen] = '{default: 1'b0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int lookup_pair(logic [15:0] key);
    for (int i = 0; i < TableLen; i++) begin
      if (pair_vld[i] && pair_key[i] == key) return i;
    end
    return TableLen;
  endfunction

  function automatic void deframe_and_match(link_item_t it);
    frame_report_t rep;
    int            frame_len;
    int            idx;
    if (it.op == drdtm_pkg::OpRegister) begin
      if (lookup_pair({it.reg_page, it.reg_object}) == TableLen) begin
        pair_key[ins_pos] = {it.reg_page, it.reg_object};
        pair_vld[ins_pos] = 1'b1;
        ins_pos = (ins_pos + 1) % TableLen;
      end
      return;
    end
    if (wr_pos < 4) head[wr_pos] = it.rx_byte;
    wr_pos++;
    if (it.rx_byte == drdtm_pkg::TermByte) begin
      ff_run++;
    end else begin
      ff_run = 0;
      // clamp so later bytes overwrite the last kept one
      if (wr_pos > BufLen - 3) wr_pos = BufLen - 3;
    end
    if (ff_run < 3) return;
    frame_len = wr_pos - 3;
    wr_pos    = 0;
    ff_run    = 0;
    rep           = '{default: '0};
    rep.msg_len   = frame_len[4:0];
    rep.code_byte = head[0];
    if (frame_len == 4 && head[0] == drdtm_pkg::TouchCode) begin
      rep.is_touch     = 1'b1;
      rep.touch_page   = head[1];
      rep.touch_object = head[2];
      rep.touch_kind   = (head[3] == 8'd0) ? drdtm_pkg::KindRelease :
                         (head[3] == 8'd1) ? drdtm_pkg::KindPress :
                                             drdtm_pkg::KindOther;
      idx = lookup_pair({head[1], head[2]});
      if (idx < TableLen) begin
        rep.hit  = 1'b1;
        rep.slot = idx[3:0];
      end
    end
    reports_due.push_back(rep);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Driver: hold the item until its transfer, then advance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) deframe_and_match(on_wire);
      if (link_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        on_wire = link_items.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.op         <= on_wire.op;
        in_ch.rx_byte    <= on_wire.rx_byte;
        in_ch.reg_page   <= on_wire.reg_page;
        in_ch.reg_object <= on_wire.reg_object;
      end else begin
        in_ch.valid      <= 1'b0;
        in_ch.op         <= 1'($urandom_range(0, 1));
        in_ch.rx_byte    <= 8'($urandom_range(0, 255));
        in_ch.reg_page   <= 8'($urandom_range(0, 255));
        in_ch.reg_object <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Receiver: a requested hold-off wins over random stalls
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, actual len %0d code %0h",
                 $time, out_ch.msg_len, out_ch.code_byte);
      end else begin
        want = reports_due.pop_front();
        check_field("msg_len", 8'(want.msg_len), 8'(out_ch.msg_len));
        check_field("code_byte", want.code_byte, out_ch.code_byte);
        check_field("is_touch", 8'(want.is_touch), 8'(out_ch.is_touch));
        check_field("touch_page", want.touch_page, out_ch.touch_page);
        check_field("touch_object", want.touch_object, out_ch.touch_object);
        check_field("touch_kind", 8'(want.touch_kind), 8'(out_ch.touch_kind));
        check_field("hit", 8'(want.hit), 8'(out_ch.hit));
        check_field("slot", 8'(want.slot), 8'(out_ch.slot));
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    link_item_t it;
    it.op         = drdtm_pkg::OpRxByte;
    it.rx_byte    = b;
    it.reg_page   = 8'($urandom_range(0, 255));
    it.reg_object = 8'($urandom_range(0, 255));
    link_items.push_back(it);
    pushed++;
  endfunction

  function automatic void push_reg(logic [7:0] page, logic [7:0] object);
    link_item_t it;
    it.op         = drdtm_pkg::OpRegister;
    it.rx_byte    = 8'($urandom_range(0, 255));
    it.reg_page   = page;
    it.reg_object = object;
    link_items.push_back(it);
    pushed++;
  endfunction

  function automatic void push_term();
    repeat (3) push_byte(drdtm_pkg::TermByte);
  endfunction

  // Overrun the buffer for most lengths so the write position gets clamped
  function automatic void push_long_frame();
    repeat ($urandom_range(26, 40)) push_byte(8'($urandom_range(0, 254)));
    push_term();
  endfunction

  function automatic void gen_traffic(int n_items);
    int          goal;
    int          pick;
    logic [15:0] pair;
    goal = pushed + n_items;
    while (pushed < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        repeat ($urandom_range(1, 3)) begin
          pair = ($urandom_range(0, 9) < 8) ? pair_pool[$urandom_range(0, PoolSize - 1)]
                                            : 16'($urandom_range(0, 65535));
          push_reg(pair[15:8], pair[7:0]);
        end
      end else if (pick < 60) begin
        pair = ($urandom_range(0, 9) < 7) ? pair_pool[$urandom_range(0, PoolSize - 1)]
                                          : 16'($urandom_range(0, 65535));
        push_byte(drdtm_pkg::TouchCode);
        push_byte(pair[15:8]);
        push_byte(pair[7:0]);
        case ($urandom_range(0, 3))
          0:       push_byte(8'd0);
          1:       push_byte(8'd1);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 254)));
        push_term();
      end else if (pick < 80) begin
        repeat ($urandom_range(0, 8)) begin
          push_byte(($urandom_range(0, 3) == 0) ? drdtm_pkg::TermByte
                                                : 8'($urandom_range(0, 255)));
        end
        push_term();
      end else if (pick < 88) begin
        push_long_frame();
      end else begin
        // noise and broken terminators
        repeat ($urandom_range(1, 4)) begin
          push_byte(($urandom_range(0, 1) == 0) ? drdtm_pkg::TermByte
                                                : 8'($urandom_range(0, 254)));
        end
      end
    end
  endfunction

  task automatic settle();
    while (link_items.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (reports_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = drdtm_pkg::OpRxByte;
    in_ch.rx_byte    = 8'h00;
    in_ch.reg_page   = 8'h00;
    in_ch.reg_object = 8'h00;
    out_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    for (int i = 0; i < PoolSize; i++) pair_pool[i] = 16'($urandom_range(0, 65535));
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: duplicate and extreme registrations, empty frame,
    // touch hit and miss, short non-touch frame
    push_reg(8'h12, 8'h34);
    push_reg(8'h12, 8'h34);
    push_reg(8'hFF, 8'hFF);
    push_reg(8'h00, 8'h00);
    push_term();
    push_byte(drdtm_pkg::TouchCode);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h01);
    push_term();
    push_byte(drdtm_pkg::TouchCode);
    push_byte(8'hAB);
    push_byte(8'hCD);
    push_byte(8'h00);
    push_term();
    push_byte(drdtm_pkg::TouchCode);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_term();
    settle();

    push_long_frame();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 83 : (phase == 3) ? 24 : 0;
      stall_pct     = (phase == 2) ? 83 : (phase == 3) ? 24 : 0;
      gen_traffic(100);
      settle();
    end

    // Hold the output long enough to back up the input
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 300;
    repeat (12) push_term();
    gen_traffic(20);
    settle();

    repeat (30) @(negedge clk_i);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("display_reply_deframer_touch_matcher_core verification clean");
    end else begin
      $display("display_reply_deframer_touch_matcher_core verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("display_reply_deframer_touch_matcher_core verification failed");
    $finish;
  end

endmodule
